[src/lls_pkg.sv]
// Shared types, constants and helpers for the token scanner.
`default_nettype none
package lls_pkg;

  localparam int OFFSET_BITS   = 16;
  localparam int KEYWORD_CHARS = 7;
  localparam int PFX_W         = 8 * KEYWORD_CHARS;
  localparam int WLEN_W        = 4;
  localparam int FIELD_W       = 16;
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int MAX_RES       = 4;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
  localparam logic [FIELD_W-1:0]     LINE_TOP = {FIELD_W{1'b1}};

  localparam logic [5:0] K_LPAREN = 6'd0;
  localparam logic [5:0] K_RPAREN = 6'd1;
  localparam logic [5:0] K_LBRACE = 6'd2;
  localparam logic [5:0] K_RBRACE = 6'd3;
  localparam logic [5:0] K_COMMA  = 6'd4;
  localparam logic [5:0] K_DOT    = 6'd5;
  localparam logic [5:0] K_MINUS  = 6'd6;
  localparam logic [5:0] K_PLUS   = 6'd7;
  localparam logic [5:0] K_SEMI   = 6'd8;
  localparam logic [5:0] K_SLASH  = 6'd9;
  localparam logic [5:0] K_STAR   = 6'd10;
  localparam logic [5:0] K_BANG   = 6'd11;
  localparam logic [5:0] K_BANG_EQ = 6'd12;
  localparam logic [5:0] K_EQ     = 6'd13;
  localparam logic [5:0] K_EQ_EQ  = 6'd14;
  localparam logic [5:0] K_GT     = 6'd15;
  localparam logic [5:0] K_GT_EQ  = 6'd16;
  localparam logic [5:0] K_LT     = 6'd17;
  localparam logic [5:0] K_LT_EQ  = 6'd18;
  localparam logic [5:0] K_IDENT  = 6'd19;
  localparam logic [5:0] K_STRING = 6'd20;
  localparam logic [5:0] K_NUMBER = 6'd21;
  localparam logic [5:0] K_KW0    = 6'd22;
  localparam logic [5:0] K_EOF    = 6'd38;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_CHAR = 2'd1;
  localparam logic [1:0] ERR_STR  = 2'd2;

  localparam logic [63:0] KW_TEXT [16] = '{
    "and", "class", "else", "false", "fun", "for", "if", "nil",
    "or", "print", "return", "super", "this", "true", "var", "while"
  };
  localparam logic [WLEN_W-1:0] KW_LEN [16] = '{
    4'd3, 4'd5, 4'd4, 4'd5, 4'd3, 4'd3, 4'd2, 4'd3,
    4'd2, 4'd5, 4'd6, 4'd5, 4'd4, 4'd4, 4'd3, 4'd5
  };

  typedef struct packed {
    logic [5:0]         kind;
    logic [1:0]         err;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] len;
    logic [FIELD_W-1:0] line;
  } res_t;

  typedef struct packed {
    logic [2:0] cnt;
    res_t [MAX_RES-1:0] res;
  } bundle_t;

endpackage
`default_nettype wire

[src/lls_front.sv]
// Front end: byte classes and scan state, one request per cycle on acc.
`default_nettype none
module lls_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             acc,
  input  wire logic [7:0]       char_byte,
  input  wire logic             has_byte,
  input  wire logic             end_of_source,
  output lls_pkg::bundle_t      bundle,
  output logic                  push
);
  import lls_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE, M_OP, M_COMMENT, M_STRING, M_INT, M_DOT, M_FRAC, M_WORD
  } mode_t;

  localparam int EW = OFFSET_BITS + 1;
  localparam logic [WLEN_W-1:0] WLEN_SAT = WLEN_W'(KEYWORD_CHARS + 1);

  mode_t                  mode_r, mode_nxt, mode_a;
  logic [7:0]             pend_r, pend_nxt, pend_a;
  logic [OFFSET_BITS-1:0] ts_r, ts_nxt, ts_a;
  logic [OFFSET_BITS-1:0] off_r, off_nxt, off_a;
  logic [FIELD_W-1:0]     line_r, line_nxt, line_a;
  logic [PFX_W-1:0]       pfx_r, pfx_nxt, pfx_a;
  logic [WLEN_W-1:0]      wlen_r, wlen_nxt, wlen_a;

  logic       run_idle;
  logic       slot_v [6];
  res_t       slot   [6];
  logic [2:0] cnt;
  logic [EW-1:0] p, p1, pm1, q, qm1, tse, tsa;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic [5:0] word_kind(input logic [PFX_W-1:0] pf,
                                           input logic [WLEN_W-1:0] wl);
    logic [5:0] k;
    k = K_IDENT;
    for (int i = 0; i < 16; i++) begin
      if (wl == KW_LEN[i] && pf == KW_TEXT[i][PFX_W-1:0]) k = K_KW0 + 6'(i);
    end
    return k;
  endfunction

  function automatic logic [5:0] op_kind(input logic [7:0] op, input logic two);
    case (op)
      "!":     return two ? K_BANG_EQ : K_BANG;
      "=":     return two ? K_EQ_EQ : K_EQ;
      ">":     return two ? K_GT_EQ : K_GT;
      "<":     return two ? K_LT_EQ : K_LT;
      default: return K_SLASH;
    endcase
  endfunction

  function automatic res_t mk(input logic [5:0] kind, input logic [1:0] err,
                              input logic [EW-1:0] s, input logic [EW-1:0] e,
                              input logic [FIELD_W-1:0] ln);
    res_t r;
    logic [EW+FIELD_W-1:0] sw, lw;
    sw = {{FIELD_W{1'b0}}, s};
    lw = (e >= s) ? {{FIELD_W{1'b0}}, e - s} : '0;
    r.kind  = kind;
    r.err   = err;
    r.start = sw[FIELD_W-1:0];
    r.len   = lw[FIELD_W-1:0];
    r.line  = ln;
    return r;
  endfunction

  always_comb begin
    mode_a   = mode_r;
    pend_a   = pend_r;
    ts_a     = ts_r;
    line_a   = line_r;
    pfx_a    = pfx_r;
    wlen_a   = wlen_r;
    run_idle = 1'b0;
    for (int i = 0; i < 6; i++) begin
      slot_v[i] = 1'b0;
      slot[i]   = '0;
    end
    p   = {1'b0, off_r};
    p1  = p + EW'(1);
    pm1 = (off_r == '0) ? '0 : p - EW'(1);
    tse = {1'b0, ts_r};

    if (has_byte) begin
      case (mode_r)
        M_OP: begin
          mode_a = M_IDLE;
          if (char_byte == "=" && pend_r != "/") begin
            slot_v[0] = 1'b1;
            slot[0]   = mk(op_kind(pend_r, 1'b1), ERR_NONE, tse, p1, line_r);
          end else if (char_byte == "/" && pend_r == "/") begin
            mode_a = M_COMMENT;
          end else begin
            slot_v[0] = 1'b1;
            slot[0]   = mk(op_kind(pend_r, 1'b0), ERR_NONE, tse, p, line_r);
            run_idle  = 1'b1;
          end
        end
        M_COMMENT: begin
          if (char_byte == 8'h0A) begin
            mode_a   = M_IDLE;
            run_idle = 1'b1;
          end
        end
        M_STRING: begin
          if (char_byte == "\"") begin
            mode_a    = M_IDLE;
            slot_v[0] = 1'b1;
            slot[0]   = mk(K_STRING, ERR_NONE, tse, p1, line_r);
          end else if (char_byte == 8'h0A && line_r != LINE_TOP) begin
            line_a = line_r + 1'b1;
          end
        end
        M_INT, M_FRAC: begin
          if (char_byte == "." && mode_r == M_INT) begin
            mode_a = M_DOT;
          end else if (!is_digit(char_byte)) begin
            mode_a    = M_IDLE;
            slot_v[0] = 1'b1;
            slot[0]   = mk(K_NUMBER, ERR_NONE, tse, p, line_r);
            run_idle  = 1'b1;
          end
        end
        M_DOT: begin
          if (is_digit(char_byte)) begin
            mode_a = M_FRAC;
          end else begin
            mode_a    = M_IDLE;
            slot_v[0] = 1'b1;
            slot[0]   = mk(K_NUMBER, ERR_NONE, tse, pm1, line_r);
            slot_v[1] = 1'b1;
            slot[1]   = mk(K_DOT, ERR_NONE, pm1, p, line_r);
            run_idle  = 1'b1;
          end
        end
        M_WORD: begin
          if (is_alpha(char_byte) || is_digit(char_byte)) begin
            if (wlen_r < WLEN_W'(KEYWORD_CHARS)) pfx_a = {pfx_r[PFX_W-9:0], char_byte};
            if (wlen_r != WLEN_SAT) wlen_a = wlen_r + 1'b1;
          end else begin
            mode_a    = M_IDLE;
            slot_v[0] = 1'b1;
            slot[0]   = mk(word_kind(pfx_r, wlen_r), ERR_NONE, tse, p, line_r);
            run_idle  = 1'b1;
          end
        end
        default: run_idle = 1'b1;
      endcase

      if (run_idle) begin
        ts_a = off_r;
        case (char_byte)
          "!", "=", "<", ">", "/": begin
            mode_a = M_OP;
            pend_a = char_byte;
          end
          "(", ")", "{", "}", ",", ".", "-", "+", ";", "*": begin
            slot_v[2] = 1'b1;
            case (char_byte)
              "(":     slot[2] = mk(K_LPAREN, ERR_NONE, p, p1, line_r);
              ")":     slot[2] = mk(K_RPAREN, ERR_NONE, p, p1, line_r);
              "{":     slot[2] = mk(K_LBRACE, ERR_NONE, p, p1, line_r);
              "}":     slot[2] = mk(K_RBRACE, ERR_NONE, p, p1, line_r);
              ",":     slot[2] = mk(K_COMMA, ERR_NONE, p, p1, line_r);
              ".":     slot[2] = mk(K_DOT, ERR_NONE, p, p1, line_r);
              "-":     slot[2] = mk(K_MINUS, ERR_NONE, p, p1, line_r);
              "+":     slot[2] = mk(K_PLUS, ERR_NONE, p, p1, line_r);
              ";":     slot[2] = mk(K_SEMI, ERR_NONE, p, p1, line_r);
              default: slot[2] = mk(K_STAR, ERR_NONE, p, p1, line_r);
            endcase
          end
          " ", 8'h0D, 8'h09: begin
          end
          8'h0A: begin
            if (line_r != LINE_TOP) line_a = line_r + 1'b1;
          end
          "\"": mode_a = M_STRING;
          default: begin
            if (is_digit(char_byte)) begin
              mode_a = M_INT;
            end else if (is_alpha(char_byte)) begin
              mode_a = M_WORD;
              pfx_a  = PFX_W'(char_byte);
              wlen_a = WLEN_W'(1);
            end else begin
              slot_v[2] = 1'b1;
              slot[2]   = mk(6'd0, ERR_CHAR, p, p1, line_r);
            end
          end
        endcase
      end
    end

    off_a = (has_byte && off_r != OFF_MAX) ? off_r + 1'b1 : off_r;
    q     = {1'b0, off_a};
    qm1   = (off_a == '0) ? '0 : q - EW'(1);
    tsa   = {1'b0, ts_a};

    if (end_of_source) begin
      case (mode_a)
        M_OP: begin
          slot_v[3] = 1'b1;
          slot[3]   = mk(op_kind(pend_a, 1'b0), ERR_NONE, tsa, q, line_a);
        end
        M_STRING: begin
          slot_v[3] = 1'b1;
          slot[3]   = mk(6'd0, ERR_STR, tsa, q, line_a);
        end
        M_INT, M_FRAC: begin
          slot_v[3] = 1'b1;
          slot[3]   = mk(K_NUMBER, ERR_NONE, tsa, q, line_a);
        end
        M_DOT: begin
          slot_v[3] = 1'b1;
          slot[3]   = mk(K_NUMBER, ERR_NONE, tsa, qm1, line_a);
          slot_v[4] = 1'b1;
          slot[4]   = mk(K_DOT, ERR_NONE, qm1, q, line_a);
        end
        M_WORD: begin
          slot_v[3] = 1'b1;
          slot[3]   = mk(word_kind(pfx_a, wlen_a), ERR_NONE, tsa, q, line_a);
        end
        default: begin
        end
      endcase
      slot_v[5] = 1'b1;
      slot[5]   = mk(K_EOF, ERR_NONE, q, q, line_a);
    end

    cnt    = '0;
    bundle = '0;
    for (int i = 0; i < 6; i++) begin
      if (slot_v[i] && cnt < 3'(MAX_RES)) begin
        bundle.res[cnt[1:0]] = slot[i];
        cnt = cnt + 3'd1;
      end
    end
    bundle.cnt = cnt;
    push       = acc && cnt != '0;

    mode_nxt = mode_r;
    pend_nxt = pend_r;
    ts_nxt   = ts_r;
    off_nxt  = off_r;
    line_nxt = line_r;
    pfx_nxt  = pfx_r;
    wlen_nxt = wlen_r;
    if (acc) begin
      if (end_of_source) begin
        mode_nxt = M_IDLE;
        pend_nxt = '0;
        ts_nxt   = '0;
        off_nxt  = '0;
        line_nxt = FIELD_W'(1);
        pfx_nxt  = '0;
        wlen_nxt = '0;
      end else begin
        mode_nxt = mode_a;
        pend_nxt = pend_a;
        ts_nxt   = ts_a;
        off_nxt  = off_a;
        line_nxt = line_a;
        pfx_nxt  = pfx_a;
        wlen_nxt = wlen_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pend_r <= '0;
      ts_r   <= '0;
      off_r  <= '0;
      line_r <= FIELD_W'(1);
      pfx_r  <= '0;
      wlen_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      ts_r   <= ts_nxt;
      off_r  <= off_nxt;
      line_r <= line_nxt;
      pfx_r  <= pfx_nxt;
      wlen_r <= wlen_nxt;
    end
  end

endmodule
`default_nettype wire

[src/lls_queue.sv]
// Short queue of result bundles between front and back.
`default_nettype none
module lls_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire lls_pkg::bundle_t wdata,
  input  wire logic             pop,
  output lls_pkg::bundle_t      rdata,
  output logic                  full,
  output logic                  empty
);
  import lls_pkg::*;

  bundle_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;

  assign full  = cnt_r == (QPTR_W+1)'(QDEPTH);
  assign empty = cnt_r == '0;
  assign rdata = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[src/lls_back.sv]
// Back end: sends a bundle's results one per ready cycle.
`default_nettype none
module lls_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lls_pkg::bundle_t head,
  input  wire logic             empty,
  output logic                  pop,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [47:0]           out_tdata,
  output logic [7:0]            out_tuser,
  output logic                  out_tlast
);
  import lls_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  res_t       cur;
  logic       fire;

  always_comb begin
    cur        = head.res[idx_r];
    out_tvalid = !empty;
    out_tdata  = {cur.line, cur.len, cur.start};
    out_tuser  = {cur.err, cur.kind};
    out_tlast  = {1'b0, idx_r} == head.cnt - 3'd1;
    fire       = out_tvalid && out_tready;
    pop        = fire && out_tlast;
    idx_nxt    = idx_r;
    if (fire) idx_nxt = out_tlast ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

[src/lox_lexer_token_scanner.sv]
// Top level of the token scanner: front end, bundle queue and back end.
// Output: a token enters the bundle queue with the request that completes it.
// Throughput: one request per cycle while each yields at most one token and
// out_tready stays high; a request yielding n tokens (n up to 4) sends them
// in turn, absorbed by the four-entry bundle queue.
// Reset: synchronous active-low rst_n empties the queue and returns to line 1.
`default_nettype none
module lox_lexer_token_scanner (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // char_byte
  input  wire logic [1:0]  in_tuser,   // has_byte, end_of_source
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // start_offset, token_length, line_number
  output logic [7:0]       out_tuser,  // token_kind, error_code
  output logic             out_tlast
);
  import lls_pkg::*;

  bundle_t fbundle, head;
  logic    push, pop, full, empty, acc;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  lls_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .char_byte     (in_tdata),
    .has_byte      (in_tuser[0]),
    .end_of_source (in_tuser[1]),
    .bundle        (fbundle),
    .push          (push)
  );

  lls_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (fbundle),
    .pop   (pop),
    .rdata (head),
    .full  (full),
    .empty (empty)
  );

  lls_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

[src/lls_checker.sv]
// Port-level checks for the token scanner, bound to the top level.
`default_nettype none
module lls_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic [7:0]  out_tuser,
  input wire logic        out_tlast
);
  import lls_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output request dropped while stalled");

  a_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:32] != '0)
    else $error("line number zero");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[5:0] == K_EOF |-> out_tlast && out_tdata[31:16] == '0)
    else $error("eof token not last or not empty");

  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[7:6] != ERR_NONE |-> out_tuser[5:0] == '0)
    else $error("error result carries a kind");

endmodule

bind lox_lexer_token_scanner lls_checker u_lls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
